FILE: src/assert_macros.svh
// assertion macros shared by the filter rtl
// no dependencies; pulled in by the files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define C3K_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define C3K_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/c3k_pkg.sv
// shared constants, types and helper functions of the 3x3 filter
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package c3k_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int PIXEL_BITS    = 8;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 12;
  localparam int ROW_BITS      = 12;
  localparam int ROW_LIMIT     = 4095;
  localparam int MIN_DIM       = 3;
  localparam int EMIT_BITS     = 22;
  localparam int WIN_COLS      = 3;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  // register indexes, decoded from paddr[3:2]
  localparam logic [1:0] REG_KMODE   = 2'd0;
  localparam logic [1:0] REG_FWIDTH  = 2'd1;
  localparam logic [1:0] REG_FHEIGHT = 2'd2;

  // kernel mode codes
  localparam logic [1:0] KM_GAUSS   = 2'd0;
  localparam logic [1:0] KM_LAPLACE = 2'd1;
  localparam logic [1:0] KM_SHARPEN = 2'd2;

  localparam logic [WIDTH_BITS-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = 12'd480;
  localparam logic [EMIT_BITS-1:0]   RST_TOTAL  = 22'd307200;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // one window column, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef col_t [WIN_COLS-1:0] win_t;

  // per-result control for the kernel stage
  typedef struct packed {
    logic zero;
    logic mask_right;
    logic mask_bottom;
  } kctl_t;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } res_t;

  function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
    logic [WIDTH_BITS-1:0] r;
    if (w < WIDTH_BITS'(MIN_DIM)) begin
      r = WIDTH_BITS'(MIN_DIM);
    end else if (w > WIDTH_BITS'(MAX_WIDTH)) begin
      r = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      r = w;
    end
    return r;
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [HEIGHT_BITS-1:0] h);
    logic [HEIGHT_BITS-1:0] r;
    if (h < HEIGHT_BITS'(MIN_DIM)) begin
      r = HEIGHT_BITS'(MIN_DIM);
    end else if (h > HEIGHT_BITS'(ROW_LIMIT)) begin
      r = HEIGHT_BITS'(ROW_LIMIT);
    end else begin
      r = h;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/c3k_if.sv
// valid/ready stream interfaces for pixel input and filtered output
// depends on c3k_pkg
`timescale 1ns / 1ps
`default_nettype none

interface c3k_in_if;
  import c3k_pkg::*;
  logic valid;
  logic ready;
  logic action;
  pix_t pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface c3k_out_if;
  import c3k_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: src/c3k_line_store.sv
// two line stores in one read-modify-write pipeline, with a clearing sweep
// depends on c3k_pkg
`timescale 1ns / 1ps
`default_nettype none

module c3k_line_store (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           rd_en_i,
  input  wire [c3k_pkg::COL_BITS-1:0]   addr_i,
  input  c3k_pkg::pix_t                 pix_i,
  output logic                          busy_o,
  output logic                          valid_o,
  output c3k_pkg::col_t                 col_o
);
  import c3k_pkg::*;

  pix_t mem_a [MAX_WIDTH];
  pix_t mem_b [MAX_WIDTH];

  logic                clr_busy_q;
  logic [COL_BITS-1:0] clr_addr_q;
  logic                s1_valid_q;
  logic [COL_BITS-1:0] s1_addr_q;
  pix_t                s1_pix_q;
  pix_t                rd_a_q, rd_b_q;
  logic                fwd_q;
  pix_t                fwd_a_q, fwd_b_q;
  pix_t                a_eff, b_eff;

  // same entry written by the previous beat: take the value being written
  assign a_eff = fwd_q ? fwd_a_q : rd_a_q;
  assign b_eff = fwd_q ? fwd_b_q : rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == COL_BITS'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      s1_valid_q <= rd_en_i;
      fwd_q      <= rd_en_i && s1_valid_q && (addr_i == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= addr_i;
    s1_pix_q  <= pix_i;
    fwd_a_q   <= s1_pix_q;
    fwd_b_q   <= a_eff;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_a[clr_addr_q] <= '0;
      mem_b[clr_addr_q] <= '0;
    end else if (s1_valid_q) begin
      mem_a[s1_addr_q] <= s1_pix_q;
      mem_b[s1_addr_q] <= a_eff;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_a[addr_i];
      rd_b_q <= mem_b[addr_i];
    end
  end

  assign busy_o  = clr_busy_q;
  assign valid_o = s1_valid_q;
  assign col_o   = '{top: b_eff, mid: a_eff, bot: s1_pix_q};

endmodule

`default_nettype wire

FILE: src/c3k_column_cell.sv
// one window column cell, takes the column of its right neighbor on a shift
// depends on c3k_pkg
`timescale 1ns / 1ps
`default_nettype none

module c3k_column_cell (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           en_i,
  input  c3k_pkg::col_t col_i,
  output c3k_pkg::col_t col_o
);
  import c3k_pkg::*;

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

FILE: src/c3k_kernel_alu.sv
// weighted 3x3 sum with edge masking and clamp to the pixel range
// depends on c3k_pkg
`timescale 1ns / 1ps
`default_nettype none

module c3k_kernel_alu (
  input  wire [1:0]      mode_i,
  input  c3k_pkg::win_t  win_i,
  input  c3k_pkg::kctl_t ctl_i,
  output c3k_pkg::pix_t  pixel_o
);
  import c3k_pkg::*;

  localparam int SUM_BITS = PIXEL_BITS + 2;
  localparam int ACC_BITS = PIXEL_BITS + 6;

  pix_t c0, c1, c2, c3, c4, c5, c6, c7, c8;
  logic [SUM_BITS-1:0]     corners, sides;
  logic [PIXEL_BITS+2:0]   ctr7;
  logic [PIXEL_BITS+3:0]   ctr9;
  logic [PIXEL_BITS+3:0]   gsum;
  logic [ACC_BITS-1:0]     acc;

  always_comb begin
    c0 = win_i[0].top;
    c1 = win_i[1].top;
    c2 = ctl_i.mask_right ? '0 : win_i[2].top;
    c3 = win_i[0].mid;
    c4 = win_i[1].mid;
    c5 = ctl_i.mask_right ? '0 : win_i[2].mid;
    c6 = ctl_i.mask_bottom ? '0 : win_i[0].bot;
    c7 = ctl_i.mask_bottom ? '0 : win_i[1].bot;
    c8 = (ctl_i.mask_right || ctl_i.mask_bottom) ? '0 : win_i[2].bot;

    corners = {2'b00, c0} + {2'b00, c2} + {2'b00, c6} + {2'b00, c8};
    sides   = {2'b00, c1} + {2'b00, c3} + {2'b00, c5} + {2'b00, c7};
    ctr7    = {c4, 3'b000} - {3'b000, c4};
    ctr9    = {1'b0, c4, 3'b000} + {4'b0000, c4};
    gsum    = {2'b00, corners} + {1'b0, sides, 1'b0} + {2'b00, c4, 2'b00};

    case (mode_i)
      KM_LAPLACE: acc = {4'b0000, corners} + {4'b0000, sides} - {3'b000, ctr7};
      KM_SHARPEN: acc = {2'b00, ctr9} - {4'b0000, corners} - {4'b0000, sides};
      default:    acc = {6'b000000, gsum[PIXEL_BITS+3:4]};
    endcase

    // clamp, negative to zero and overflow to full scale; a zeroed result gives zero
    if (ctl_i.zero || acc[ACC_BITS-1]) begin
      pixel_o = '0;
    end else if (|acc[ACC_BITS-2:PIXEL_BITS]) begin
      pixel_o = '1;
    end else begin
      pixel_o = acc[PIXEL_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/conv3x3_kernel_select_filter_unit.sv
// top level of the 3x3 kernel-select filter: raster counters, config port,
// line stores, column cell chain, kernel stage and output fifo
// depends on c3k_pkg, c3k_if, assert_macros.svh and all c3k_* modules
`timescale 1ns / 1ps
`default_nettype none

//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------
//  in_i     | in  | valid / ready      | action, pixel_in
//  out_o    | out | valid / ready      | pixel_out, frame_last
//  apb      | in  | psel, penable (wr) | paddr, pwdata -> prdata
//
// one pixel beat per clock while in_i.ready is high; the result of the beat that
// completes its window passes the line store read, column shift and kernel stage
// after reset the line stores are swept to zero, all 1024 entries, with in_i.ready low
// the four entry output fifo decouples the sides; outside the sweep in_i.ready drops
// only when results in flight plus stored ones would exceed the fifo
// config writes are taken at any time, pready is always high

module conv3x3_kernel_select_filter_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  c3k_in_if.sink                             in_i,
  c3k_out_if.source                          out_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [c3k_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire [c3k_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [c3k_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import c3k_pkg::*;
  `include "assert_macros.svh"

  // ---------------------------------------------------------------- config
  logic [1:0]             mode_q, mode_d;
  logic [WIDTH_BITS-1:0]  width_q, width_d, w_eff_q, w_eff_d;
  logic [HEIGHT_BITS-1:0] height_q, height_d, h_eff_q, h_eff_d;
  logic [EMIT_BITS-1:0]   total_q, total_d;
  logic [WIDTH_BITS+HEIGHT_BITS-1:0] total_prod;
  logic                   cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    mode_d   = mode_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we) begin
      case (paddr[3:2])
        REG_KMODE:   mode_d   = pwdata[1:0];
        REG_FWIDTH:  width_d  = pwdata[WIDTH_BITS-1:0];
        REG_FHEIGHT: height_d = pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
    // saturated size and pixel count follow the written value at once
    w_eff_d    = eff_width(width_d);
    h_eff_d    = eff_height(height_d);
    total_prod = {{HEIGHT_BITS{1'b0}}, w_eff_d} * {{WIDTH_BITS{1'b0}}, h_eff_d};
    total_d    = total_prod[EMIT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= KM_GAUSS;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      w_eff_q  <= RST_WIDTH;
      h_eff_q  <= RST_HEIGHT;
      total_q  <= RST_TOTAL;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
      w_eff_q  <= w_eff_d;
      h_eff_q  <= h_eff_d;
      total_q  <= total_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KMODE:   prdata = APB_DATA_BITS'(mode_q);
      REG_FWIDTH:  prdata = APB_DATA_BITS'(width_q);
      REG_FHEIGHT: prdata = APB_DATA_BITS'(height_q);
      default:     prdata = '0;
    endcase
  end

  // ------------------------------------------------- raster position (s0)
  logic [COL_BITS-1:0]   col_q;
  logic [ROW_BITS-1:0]   row_q;
  logic [EMIT_BITS-1:0]  emit_cnt_q;
  logic                  in_acc, in_rdy;
  pix_t                  s0_pix;
  logic                  s0_emit, s0_last, s0_wrap, col_zero;
  logic [WIDTH_BITS-1:0] col_inc;
  logic [ROW_BITS-1:0]   cy;
  logic [EMIT_BITS-1:0]  emit_inc;
  kctl_t                 s0_kctl;

  assign in_acc   = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;

  always_comb begin
    // padding and pixels past the last row enter as zero
    s0_pix   = (in_i.action || (row_q >= h_eff_q)) ? '0 : in_i.pixel_in;
    s0_emit  = (row_q >= ROW_BITS'(2)) || ((row_q == ROW_BITS'(1)) && (col_q != '0));
    col_inc  = {1'b0, col_q} + 1'b1;
    s0_wrap  = col_inc >= w_eff_q;
    col_zero = (col_q == '0);
    // row of the window centre; on column zero the centre is the previous row end
    cy       = col_zero ? (row_q - ROW_BITS'(2)) : (row_q - ROW_BITS'(1));
    emit_inc = emit_cnt_q + 1'b1;
    s0_last  = s0_emit && (emit_inc >= total_q);
    s0_kctl.zero        = (col_q == COL_BITS'(1)) || (cy == '0);
    s0_kctl.mask_right  = col_zero;
    s0_kctl.mask_bottom = ({1'b0, cy} + 1'b1) >= {1'b0, h_eff_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      emit_cnt_q <= '0;
    end else if (in_acc) begin
      if (s0_last) begin
        col_q      <= '0;
        row_q      <= '0;
        emit_cnt_q <= '0;
      end else begin
        col_q <= s0_wrap ? '0 : col_inc[COL_BITS-1:0];
        if (s0_wrap && (row_q != ROW_BITS'(ROW_LIMIT))) begin
          row_q <= row_q + 1'b1;
        end
        if (s0_emit) begin
          emit_cnt_q <= emit_inc;
        end
      end
    end
  end

  // ------------------------------------------------- line stores (s0 -> s1)
  logic ls_busy, ls_valid;
  col_t ls_col;

  c3k_line_store u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_acc),
    .addr_i  (col_q),
    .pix_i   (s0_pix),
    .busy_o  (ls_busy),
    .valid_o (ls_valid),
    .col_o   (ls_col)
  );

  // ------------------------------------------- window cell chain (s1 -> s2)
  // the newest column enters the rightmost cell and moves left each beat
  win_t win;

  for (genvar j = 0; j < WIN_COLS; j++) begin : g_cell
    col_t cell_in;
    if (j == WIN_COLS - 1) begin : g_head
      assign cell_in = ls_col;
    end else begin : g_link
      assign cell_in = win[j+1];
    end
    c3k_column_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (ls_valid),
      .col_i  (cell_in),
      .col_o  (win[j])
    );
  end

  // control travels alongside the data
  logic  s1_emit_q, s1_last_q, s2_emit_q, s2_last_q;
  kctl_t s1_kctl_q, s2_kctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_emit_q <= 1'b0;
      s2_emit_q <= 1'b0;
    end else begin
      s1_emit_q <= in_acc && s0_emit;
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= s0_last;
    s1_kctl_q <= s0_kctl;
    s2_last_q <= s1_last_q;
    s2_kctl_q <= s1_kctl_q;
  end

  // ------------------------------------------------------ kernel stage (s2)
  pix_t alu_pix;

  c3k_kernel_alu u_kernel_alu (
    .mode_i  (mode_q),
    .win_i   (win),
    .ctl_i   (s2_kctl_q),
    .pixel_o (alu_pix)
  );

  // ------------------------------------------------------------ output fifo
  res_t                     fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt_q, occ;
  logic                     out_pop;
  res_t                     head;

  assign out_pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (s2_emit_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (s2_emit_q && !out_pop) begin
        fifo_cnt_q <= fifo_cnt_q + 1'b1;
      end else if (!s2_emit_q && out_pop) begin
        fifo_cnt_q <= fifo_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_emit_q) begin
      fifo_q[wr_ptr_q] <= '{pixel: alu_pix, last: s2_last_q};
    end
  end

  assign head             = fifo_q[rd_ptr_q];
  assign out_o.valid      = (fifo_cnt_q != '0);
  assign out_o.pixel_out  = head.pixel;
  assign out_o.frame_last = head.last;

  // results in flight plus stored ones never exceed the fifo
  assign occ    = {{(FIFO_CNT_BITS-1){1'b0}}, s1_emit_q}
                + {{(FIFO_CNT_BITS-1){1'b0}}, s2_emit_q} + fifo_cnt_q;
  assign in_rdy = !ls_busy && (occ < FIFO_CNT_BITS'(FIFO_DEPTH));

  // ------------------------------------------------------------- checks
  `C3K_ASSERT_NEVER(a_occ_bound, clk_i, rst_ni, occ > FIFO_CNT_BITS'(FIFO_DEPTH), "fifo credit exceeded")
  `C3K_ASSERT(a_col_follows, clk_i, rst_ni, in_acc |=> ls_valid, "line store column missing after beat")
  `C3K_ASSERT(a_frame_restart, clk_i, rst_ni, (in_acc && s0_last) |=> ((col_q == '0) && (row_q == '0) && (emit_cnt_q == '0)), "frame counters not cleared after last result")

endmodule

`default_nettype wire

FILE: dv/conv3x3_kernel_select_filter_unit_tb.sv
// self-checking testbench of the 3x3 kernel-select filter: raster pixel frames in,
// filtered pixels out, every result checked against a cycle-free predictor
// depends on c3k_pkg, c3k_if and the filter rtl
`timescale 1ns / 1ps

module conv3x3_kernel_select_filter_unit_tb;
  import c3k_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  // covers a result passing the pipeline after its last window beat, plus margin
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  // covers the line store sweep after reset and the long output hold
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 20;
  localparam int RANDOM_BEATS  = 420;
  // beats sent at the reset width, short enough to stay in row 0
  localparam int RESET_RUN_BEATS = 24;
  // beats sent into the widest and the tallest frame before they are cut short
  localparam int WIDE_RUN_BEATS  = 40;
  localparam int TALL_RUN_BEATS  = 30;
  // mode code with no kernel of its own, behaves as gaussian
  localparam logic [1:0] KM_UNUSED = 2'd3;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  c3k_in_if  pix_in ();
  c3k_out_if pix_out ();

  conv3x3_kernel_select_filter_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_in.sink),
    .out_o   (pix_out.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // filter predictor state: registers, line stores, window, raster position
  logic [1:0]             kernel_sel;
  logic [WIDTH_BITS-1:0]  row_width;
  logic [HEIGHT_BITS-1:0] frame_rows;
  pix_t                   line_above [MAX_WIDTH];
  pix_t                   line_two_above [MAX_WIDTH];
  pix_t                   window [9];
  int unsigned            next_col;
  int unsigned            next_row;
  int unsigned            results_in_frame;
  res_t                   pending_results [$];

  // stimulus knobs and run statistics
  bit tx_idle;
  bit rx_idle;
  int hold_requests;
  int holds_served;
  int beats_in;
  int results_seen;
  int frames_closed;
  int mismatches;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned lo,
                                            input int unsigned hi);
    if (raw < lo) return lo;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // extremes are favored so that clamping happens often
  function automatic pix_t rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return pix_t'($urandom_range(0, 255));
  endfunction

  // advances the filter by one input beat; returns 1 when the beat yields a result
  function automatic bit predict_pixel(input logic act, input pix_t px, output res_t r);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    int unsigned idx;
    int unsigned total;
    int unsigned cx;
    int unsigned cy;
    pix_t        v;
    int          cells [9];
    int          corners;
    int          sides;
    int          ctr;
    int          sum;
    bit          emit;
    w     = clamp_dim(row_width, MIN_DIM, MAX_WIDTH);
    h     = clamp_dim(frame_rows, MIN_DIM, ROW_LIMIT);
    col   = next_col;
    row   = next_row;
    idx   = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
    // padding and anything past the last row enter as zero
    v     = (act || row >= h) ? 8'd0 : px;
    total = w * h;
    r     = '0;

    for (int k = 0; k < 3; k++) begin
      window[k*3]   = window[k*3+1];
      window[k*3+1] = window[k*3+2];
    end
    window[2]           = line_two_above[idx];
    window[5]           = line_above[idx];
    window[8]           = v;
    line_two_above[idx] = line_above[idx];
    line_above[idx]     = v;

    emit = (row >= 2) || (row == 1 && col >= 1);
    if (next_col + 1 >= w) begin
      next_col = 0;
      if (next_row < ROW_LIMIT) next_row++;
    end else begin
      next_col++;
    end
    if (!emit) return 1'b0;

    // window centre lags the input by one row and one column
    cx = (col == 0) ? w - 1 : col - 1;
    cy = (col == 0) ? row - 2 : row - 1;
    if (cx != 0 && cy != 0) begin
      for (int k = 0; k < 9; k++) cells[k] = window[k];
      if (col == 0) begin
        // centre on the last column: right neighbors lie off the frame
        cells[2] = 0;
        cells[5] = 0;
        cells[8] = 0;
      end
      if (cy + 1 >= h) begin
        // centre on the last row: lower neighbors lie off the frame
        cells[6] = 0;
        cells[7] = 0;
        cells[8] = 0;
      end
      corners = cells[0] + cells[2] + cells[6] + cells[8];
      sides   = cells[1] + cells[3] + cells[5] + cells[7];
      ctr     = cells[4];
      case (kernel_sel)
        KM_LAPLACE: sum = corners + sides - 7 * ctr;
        KM_SHARPEN: sum = 9 * ctr - corners - sides;
        default:    sum = (corners + 2 * sides + 4 * ctr) / 16;
      endcase
      r.pixel = (sum < 0) ? 8'd0 : (sum > 255) ? 8'd255 : pix_t'(sum);
    end
    results_in_frame = (results_in_frame + 1) & 32'h003F_FFFF;
    r.last = (results_in_frame >= total);
    if (r.last) begin
      results_in_frame = 0;
      next_col         = 0;
      next_row         = 0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // input beats feed the predictor, output beats are checked in order
  always @(posedge clk_i) begin
    res_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni && pix_in.valid && pix_in.ready) begin
      moved = 1'b1;
      beats_in++;
      if (predict_pixel(pix_in.action, pix_in.pixel_in, want)) pending_results.push_back(want);
    end
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      moved = 1'b1;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing pending (pixel_out %0d)",
                                  results_seen, pix_out.pixel_out));
      end else begin
        want = pending_results.pop_front();
        if (pix_out.pixel_out !== want.pixel)
          report_mismatch($sformatf("pixel_out got %0d want %0d at result beat %0d",
                                    pix_out.pixel_out, want.pixel, results_seen));
        if (pix_out.frame_last !== want.last)
          report_mismatch($sformatf("frame_last got %0b want %0b at result beat %0d",
                                    pix_out.frame_last, want.last, results_seen));
        if (want.last) frames_closed++;
      end
    end
    // watchdog on cycles with no beat on either side
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_results.size());
      $display("FAIL conv3x3_kernel_select_filter_unit");
      $finish;
    end
  end

  // output side: random stalls, plus a long hold whenever a test asks for one
  initial begin
    int stall_left;
    stall_left   = 0;
    holds_served = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) stall_left = idle_length();
      if (stall_left > 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // offers one beat, after an optional gap, and returns at the edge that takes it;
  // valid stays high so back-to-back beats need no second assignment in a step
  task automatic send_beat(input logic act, input pix_t px);
    int gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.action   <= act;
    pix_in.pixel_in <= px;
    do @(posedge clk_i); while (pix_in.ready !== 1'b1);
  endtask

  // stop offering, let every pending result drain and the pipeline settle
  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KMODE:   kernel_sel = val[1:0];
      REG_FWIDTH:  row_width  = val[WIDTH_BITS-1:0];
      REG_FHEIGHT: frame_rows = val[HEIGHT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_frame(input logic [1:0] mode, input int unsigned w,
                               input int unsigned h);
    wait_idle();
    write_reg(REG_KMODE, 32'(mode));
    write_reg(REG_FWIDTH, w);
    write_reg(REG_FHEIGHT, h);
  endtask

  // w*h pixel beats with random content, padding beats mixed in at pad_pct percent
  task automatic send_frame(input int unsigned w, input int unsigned h, input int pad_pct);
    for (int unsigned i = 0; i < w * h; i++)
      send_beat($urandom_range(0, 99) < pad_pct, rand_pixel());
  endtask

  // w+1 trailing beats, mostly padding, some stray real pixels past the frame
  task automatic send_flush(input int unsigned w);
    for (int unsigned i = 0; i <= w; i++) send_beat($urandom_range(0, 9) != 0, rand_pixel());
  endtask

  // pads one beat at a time until the predictor sees the frame end; call when idle
  task automatic close_frame();
    while (next_col != 0 || next_row != 0 || results_in_frame != 0) begin
      send_beat(1'b1, rand_pixel());
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // reset register values: gaussian, 640 wide, so a short run yields nothing;
  // then a resize to 3x3 mid-frame
  task automatic test_reset_defaults();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (RESET_RUN_BEATS) send_beat(1'b0, rand_pixel());
    wait_idle();
    write_reg(REG_FWIDTH, 32'd3);
    write_reg(REG_FHEIGHT, 32'd3);
    close_frame();
  endtask

  // two 3x3 frames of extreme pixels: clamping both ways, edge masking,
  // padding inside the frame, a real pixel past the frame, saturated sizes
  task automatic test_directed_edges();
    bit   sharp_act [13] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 1, 1};
    pix_t sharp_px  [13] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                             8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
    bit   lap_act   [13] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1};
    pix_t lap_px    [13] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0,
                             8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    program_frame(KM_SHARPEN, 3, 3);
    for (int i = 0; i < 13; i++) send_beat(sharp_act[i], sharp_px[i]);
    // width 0 and height 2 both saturate to 3
    program_frame(KM_LAPLACE, 0, 2);
    for (int i = 0; i < 13; i++) send_beat(lap_act[i], lap_px[i]);
  endtask

  // narrower frame and new kernel while the column count sits past the new width
  task automatic test_midframe_change();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    program_frame(KM_LAPLACE, 6, 5);
    repeat (15) send_beat(1'b0, rand_pixel());
    wait_idle();
    write_reg(REG_FWIDTH, 32'd3);
    write_reg(REG_KMODE, 32'(KM_SHARPEN));
    close_frame();
  endtask

  // output held off for a long stretch while input keeps coming at full rate
  task automatic test_backpressure();
    program_frame(KM_GAUSS, 8, 4);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_requests++;
    send_frame(8, 4, 0);
    send_flush(8);
    // sender pauses until every result has come out
    wait_idle();
    rx_idle = 1'b1;
    send_frame(8, 4, 5);
    send_flush(8);
  endtask

  // widest row (register value saturates to 1024) and tallest frame, each cut
  // short and closed at 3 wide or 3 tall; the tall one ends on a count already past
  task automatic test_extreme_sizes();
    program_frame(KM_SHARPEN, 2047, 3);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    repeat (WIDE_RUN_BEATS) send_beat(1'b0, rand_pixel());
    wait_idle();
    write_reg(REG_FWIDTH, 32'd3);
    close_frame();
    program_frame(KM_UNUSED, 1, ROW_LIMIT);
    repeat (TALL_RUN_BEATS) send_beat(1'b0, rand_pixel());
    wait_idle();
    write_reg(REG_FHEIGHT, 32'd3);
    close_frame();
  endtask

  // mostly whole frames of random size and content, some cut short and reconfigured
  task automatic test_random_frames();
    int          sent;
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned w;
    int unsigned h;
    int unsigned part;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      raw_w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) :
              ($urandom_range(0, 9) == 0)  ? $urandom_range(11, 40) : $urandom_range(3, 10);
      raw_h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      w     = clamp_dim(raw_w, MIN_DIM, MAX_WIDTH);
      h     = clamp_dim(raw_h, MIN_DIM, ROW_LIMIT);
      program_frame(2'($urandom_range(0, 3)), raw_w, raw_h);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        // broken frame: stop part way, change settings, pad to the end
        part = $urandom_range(1, w * h - 1);
        for (int unsigned i = 0; i < part; i++) send_beat(1'b0, rand_pixel());
        sent += part;
        wait_idle();
        write_reg(REG_KMODE, 32'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 1) write_reg(REG_FWIDTH, $urandom_range(3, 10));
        close_frame();
      end else begin
        send_frame(w, h, 5);
        send_flush(w);
        sent += w * h + w + 1;
      end
    end
  endtask

  initial begin
    kernel_sel       = KM_GAUSS;
    row_width        = RST_WIDTH;
    frame_rows       = RST_HEIGHT;
    next_col         = 0;
    next_row         = 0;
    results_in_frame = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i]     = '0;
      line_two_above[i] = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    hold_requests = 0;
    beats_in      = 0;
    results_seen  = 0;
    frames_closed = 0;
    mismatches    = 0;
    idle_cycles   = 0;

    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_in.valid    <= 1'b0;
    pix_in.action   <= 1'b0;
    pix_in.pixel_in <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_edges();
    test_midframe_change();
    test_backpressure();
    test_extreme_sizes();
    test_random_frames();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d input beats, %0d result beats, %0d frames, all four mode codes",
             beats_in, results_seen, frames_closed);
    $display("widths saturated up to 1024, heights up to 4095, mid-frame resizes, %0d %s",
             mismatches, "mismatches");
    if (mismatches == 0) begin
      $display("PASS conv3x3_kernel_select_filter_unit");
    end else begin
      $display("FAIL conv3x3_kernel_select_filter_unit");
    end
    $finish;
  end

endmodule

FILE: conv3x3_kernel_select_filter_unit.f
+incdir+src
src/c3k_pkg.sv
src/c3k_if.sv
src/c3k_line_store.sv
src/c3k_column_cell.sv
src/c3k_kernel_alu.sv
src/conv3x3_kernel_select_filter_unit.sv
dv/conv3x3_kernel_select_filter_unit_tb.sv
